// ----- hw/rtl/pcq_pkg.sv -----
// Shared types and constants of the per-class ordered wait queue.
package pcq_pkg;

   localparam int CLASS_W    = 16;
   localparam int RECORD_W   = 31;
   localparam int SEQ_W      = 16;
   localparam int ARRIVAL_W  = 40;
   localparam int COUNT_W    = 7;
   localparam int KIND_W     = 2;
   localparam int STATUS_W   = 2;
   localparam int GROUP_SIZE = 8;

   typedef enum logic [KIND_W-1:0] {
      KIND_INSERT = 2'd0,
      KIND_REMOVE = 2'd1,
      KIND_CLEAR  = 2'd2
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_DONE    = 2'd0,
      STATUS_SKIPPED = 2'd1,
      STATUS_FULL    = 2'd2,
      STATUS_EMPTY   = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MATCH,
      ST_APPLY,
      ST_COUNT,
      ST_SUM,
      ST_FINISH
   } state_type;

   // One stored entry, apart from its timestamp whose width is a parameter.
   typedef struct packed {
      logic                valid;
      logic [CLASS_W-1:0]  class_id;
      logic [SEQ_W-1:0]    sequence_number;
      logic [RECORD_W-1:0] record_id;
   } slot_type;

   // Commands broadcast from the sequencer to every cell.
   typedef struct packed {
      logic eval;
      logic ins;
      logic rem;
      logic clr;
   } cell_ctrl_type;

endpackage

// ----- hw/rtl/pcq_req_if.sv -----
// Request channel interface of the per-class ordered wait queue.
interface pcq_req_if import pcq_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [KIND_W-1:0]    kind;
   logic [CLASS_W-1:0]   class_id;
   logic [RECORD_W-1:0]  record_id;
   logic [ARRIVAL_W-1:0] arrival_time;
   logic [SEQ_W-1:0]     sequence_number;
   logic                 is_waiting;

   modport source (output valid, kind, class_id, record_id, arrival_time,
                   sequence_number, is_waiting, input ready);
   modport sink (input valid, kind, class_id, record_id, arrival_time,
                 sequence_number, is_waiting, output ready);
endinterface

// ----- hw/rtl/pcq_rsp_if.sv -----
// Response channel interface of the per-class ordered wait queue.
interface pcq_rsp_if import pcq_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic                found;
   logic [RECORD_W-1:0] removed_record;
   logic [COUNT_W-1:0]  class_count;

   modport source (output valid, status, found, removed_record, class_count,
                   input ready);
   modport sink (input valid, status, found, removed_record, class_count,
                 output ready);
endinterface

// ----- hw/rtl/per_class_ordered_wait_queue.sv -----
// Top level of the per-class ordered wait queue: sequencer, cell row and result register.
//
// The block keeps up to QUEUE_DEPTH waiting entries sorted by class, then arrival
// time, then sequence number, in a row of cells. Each request transaction on req_ch
// carries a kind: insert an entry, remove the first entry of a class, or clear the
// store. Each request yields exactly one response transaction on rsp_ch with a
// status, a found flag, the removed record id and the count of the class left.
//
// A request is taken only while the sequencer is idle. After acceptance, every cell
// compares its entry against the key, then all cells insert, shift or clear in
// parallel, then every cell compares the class again, and the class count is added
// up through a registered adder tree before the response is loaded. The block takes
// the next request only after it has loaded this response and gone back to idle.
//
// The response sits in an output register. While the receiver stalls, the block
// still accepts and works on the next request, and holds its finished response
// until the register frees up. Synchronous reset empties the store by clearing
// every cell's valid bit, and drops any pending response.
module per_class_ordered_wait_queue import pcq_pkg::*; #(
   parameter int QUEUE_DEPTH = 64,
   parameter int TIME_BITS   = 40
) (
   input logic     clock,
   input logic     reset,
   pcq_req_if.sink   req_ch,
   pcq_rsp_if.source rsp_ch
);

   localparam int GROUPS  = (QUEUE_DEPTH + GROUP_SIZE - 1) / GROUP_SIZE;
   localparam int GROUP_W = $clog2(GROUP_SIZE + 1);
   localparam int FULL_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int TOTAL_W = (FULL_W > COUNT_W) ? FULL_W : COUNT_W;

   state_type            state_ff, state_in;
   logic [KIND_W-1:0]    kind_ff, kind_in;
   slot_type             cmd_ff, cmd_in;
   logic [TIME_BITS-1:0] cmd_time_ff, cmd_time_in;
   logic                 waiting_ff, waiting_in;
   status_type           status_ff, status_in;
   logic                 found_ff, found_in;
   logic [RECORD_W-1:0]  removed_ff, removed_in;
   logic [GROUP_W-1:0]   group_sum_ff [GROUPS];
   logic [GROUP_W-1:0]   group_sum_in [GROUPS];
   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           rsp_status_ff, rsp_status_in;
   logic                 rsp_found_ff, rsp_found_in;
   logic [RECORD_W-1:0]  rsp_removed_ff, rsp_removed_in;
   logic [COUNT_W-1:0]   rsp_count_ff, rsp_count_in;

   logic [TIME_BITS-1:0] req_time;
   cell_ctrl_type        ctrl;
   slot_type             slot_w   [QUEUE_DEPTH];
   logic [TIME_BITS-1:0] time_w   [QUEUE_DEPTH];
   logic                 keep_w   [QUEUE_DEPTH];
   logic                 match_w  [QUEUE_DEPTH];
   slot_type             empty_slot;
   logic                 any_match;
   logic                 full;
   logic [RECORD_W-1:0]  first_record;
   logic [TOTAL_W-1:0]   total;

   // Only the low TIME_BITS of the arrival time take part in the ordering.
   generate
      if (TIME_BITS <= ARRIVAL_W) begin : g_time_cut
         assign req_time = req_ch.arrival_time[TIME_BITS-1:0];
      end else begin : g_time_pad
         assign req_time = {{(TIME_BITS-ARRIVAL_W){1'b0}}, req_ch.arrival_time};
      end
   endgenerate

   assign empty_slot = '0;

   // The row of cells. Each cell sees its neighbors for shifting in either direction.
   generate
      for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
         slot_type             left_slot, right_slot;
         logic [TIME_BITS-1:0] left_time, right_time;
         logic                 left_keep;

         if (i == 0) begin : g_first
            assign left_slot = cmd_ff;
            assign left_time = cmd_time_ff;
            assign left_keep = 1'b1;
         end else begin : g_inner_left
            assign left_slot = slot_w[i-1];
            assign left_time = time_w[i-1];
            assign left_keep = keep_w[i-1];
         end

         if (i == QUEUE_DEPTH - 1) begin : g_last
            assign right_slot = empty_slot;
            assign right_time = '0;
         end else begin : g_inner_right
            assign right_slot = slot_w[i+1];
            assign right_time = time_w[i+1];
         end

         pcq_cell #(
            .TIME_BITS (TIME_BITS)
         ) u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctrl       (ctrl),
            .new_slot   (cmd_ff),
            .new_time   (cmd_time_ff),
            .left_slot  (left_slot),
            .left_time  (left_time),
            .left_keep  (left_keep),
            .right_slot (right_slot),
            .right_time (right_time),
            .slot       (slot_w[i]),
            .slot_time  (time_w[i]),
            .keep       (keep_w[i]),
            .match      (match_w[i])
         );
      end
   endgenerate

   // Entries of one class sit next to each other, so the first match is the
   // matching cell whose upper neighbor does not match.
   always_comb begin
      any_match    = 1'b0;
      first_record = '0;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         any_match = any_match | match_w[i];
         if (match_w[i] && (i == 0 || !match_w[(i == 0) ? 0 : i - 1])) begin
            first_record = first_record | slot_w[i].record_id;
         end
      end
   end

   assign full = slot_w[QUEUE_DEPTH-1].valid;

   // Final level of the count tree: the group subtotals.
   always_comb begin
      total = '0;
      for (int g = 0; g < GROUPS; g++) begin
         total = total + TOTAL_W'(group_sum_ff[g]);
      end
   end

   // First level of the count tree: matches within each group of cells.
   always_comb begin
      for (int g = 0; g < GROUPS; g++) begin
         group_sum_in[g] = '0;
         for (int j = 0; j < GROUP_SIZE; j++) begin
            if (g * GROUP_SIZE + j < QUEUE_DEPTH) begin
               group_sum_in[g] = group_sum_in[g] +
                  GROUP_W'(match_w[(g * GROUP_SIZE + j < QUEUE_DEPTH) ?
                                   g * GROUP_SIZE + j : 0]);
            end
         end
      end
   end

   // Sequencer: next state, cell commands and the result registers.
   always_comb begin
      state_in       = state_ff;
      kind_in        = kind_ff;
      cmd_in         = cmd_ff;
      cmd_time_in    = cmd_time_ff;
      waiting_in     = waiting_ff;
      status_in      = status_ff;
      found_in       = found_ff;
      removed_in     = removed_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_found_in   = rsp_found_ff;
      rsp_removed_in = rsp_removed_ff;
      rsp_count_in   = rsp_count_ff;
      ctrl           = '0;
      req_ch.ready   = 1'b0;

      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            // Ready is high throughout this state, so valid alone marks the transaction.
            req_ch.ready = 1'b1;
            if (req_ch.valid) begin
               kind_in                = req_ch.kind;
               cmd_in.valid           = 1'b1;
               cmd_in.class_id        = req_ch.class_id;
               cmd_in.sequence_number = req_ch.sequence_number;
               cmd_in.record_id       = req_ch.record_id;
               cmd_time_in            = req_time;
               waiting_in             = req_ch.is_waiting;
               state_in               = ST_MATCH;
            end
         end
         ST_MATCH: begin
            ctrl.eval = 1'b1;
            state_in  = ST_APPLY;
         end
         ST_APPLY: begin
            status_in  = STATUS_DONE;
            found_in   = 1'b0;
            removed_in = '0;
            if (kind_ff == KIND_INSERT) begin
               if (!waiting_ff) begin
                  status_in = STATUS_SKIPPED;
               end else if (full) begin
                  status_in = STATUS_FULL;
               end else begin
                  ctrl.ins = 1'b1;
               end
            end else if (kind_ff == KIND_REMOVE) begin
               if (any_match) begin
                  ctrl.rem   = 1'b1;
                  found_in   = 1'b1;
                  removed_in = first_record;
               end else begin
                  status_in = STATUS_EMPTY;
               end
            end else if (kind_ff == KIND_CLEAR) begin
               ctrl.clr = 1'b1;
            end
            state_in = ST_COUNT;
         end
         ST_COUNT: begin
            ctrl.eval = 1'b1;
            state_in  = ST_SUM;
         end
         ST_SUM: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = status_ff;
               rsp_found_in   = found_ff;
               rsp_removed_in = removed_ff;
               rsp_count_in   = total[COUNT_W-1:0];
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff        <= kind_in;
      cmd_ff         <= cmd_in;
      cmd_time_ff    <= cmd_time_in;
      waiting_ff     <= waiting_in;
      status_ff      <= status_in;
      found_ff       <= found_in;
      removed_ff     <= removed_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_found_ff   <= rsp_found_in;
      rsp_removed_ff <= rsp_removed_in;
      rsp_count_ff   <= rsp_count_in;
      for (int g = 0; g < GROUPS; g++) begin
         group_sum_ff[g] <= group_sum_in[g];
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.status         = rsp_status_ff;
   assign rsp_ch.found          = rsp_found_ff;
   assign rsp_ch.removed_record = rsp_removed_ff;
   assign rsp_ch.class_count    = rsp_count_ff;

endmodule

// ----- hw/rtl/pcq_cell.sv -----
// One storage cell of the sorted queue row.
module pcq_cell import pcq_pkg::*; #(
   parameter int TIME_BITS = 40
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cell_ctrl_type        ctrl,
   input  slot_type             new_slot,
   input  logic [TIME_BITS-1:0] new_time,
   input  slot_type             left_slot,
   input  logic [TIME_BITS-1:0] left_time,
   input  logic                 left_keep,
   input  slot_type             right_slot,
   input  logic [TIME_BITS-1:0] right_time,
   output slot_type             slot,
   output logic [TIME_BITS-1:0] slot_time,
   output logic                 keep,
   output logic                 match
);

   slot_type             slot_ff, slot_in;
   logic [TIME_BITS-1:0] time_ff, time_in;
   logic                 keep_ff, keep_in;
   logic                 match_ff, match_in;
   logic                 ahead;
   logic                 below;

   always_comb begin
      below = slot_ff.valid && (slot_ff.class_id < new_slot.class_id);
      if (slot_ff.class_id != new_slot.class_id) begin
         ahead = slot_ff.class_id < new_slot.class_id;
      end else if (time_ff != new_time) begin
         ahead = time_ff < new_time;
      end else begin
         ahead = slot_ff.sequence_number < new_slot.sequence_number;
      end

      keep_in  = keep_ff;
      match_in = match_ff;
      if (ctrl.eval) begin
         keep_in  = slot_ff.valid && ahead;
         match_in = slot_ff.valid && (slot_ff.class_id == new_slot.class_id);
      end

      slot_in = slot_ff;
      time_in = time_ff;
      if (ctrl.clr) begin
         slot_in.valid = 1'b0;
      end else if (ctrl.ins && !keep_ff) begin
         // The first cell not ahead of the new key takes it; later ones shift down.
         if (left_keep) begin
            slot_in = new_slot;
            time_in = new_time;
         end else begin
            slot_in = left_slot;
            time_in = left_time;
         end
      end else if (ctrl.rem && !below) begin
         // From the first entry of the class onward, everything moves up one.
         slot_in = right_slot;
         time_in = right_time;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff.valid <= 1'b0;
      end else begin
         slot_ff.valid <= slot_in.valid;
      end
      slot_ff.class_id        <= slot_in.class_id;
      slot_ff.sequence_number <= slot_in.sequence_number;
      slot_ff.record_id       <= slot_in.record_id;
      time_ff                 <= time_in;
      keep_ff                 <= keep_in;
      match_ff                <= match_in;
   end

   assign slot      = slot_ff;
   assign slot_time = time_ff;
   assign keep      = keep_ff;
   assign match     = match_ff;

endmodule

// ----- dv/per_class_ordered_wait_queue_tb.sv -----
`timescale 1ns / 1ps

// Self-checking testbench of the per-class ordered wait queue: directed, fill and random traffic.
module per_class_ordered_wait_queue_tb import pcq_pkg::*; ();

   localparam int QUEUE_DEPTH = 64;
   localparam int TIME_BITS   = 40;

   // The kind code that the block does not define; it must leave the store alone.
   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

   localparam logic [ARRIVAL_W-1:0] TIME_MASK =
      ARRIVAL_W'((65'd1 << TIME_BITS) - 65'd1);

   // Receiver hold-off long enough to fill the request side and stall it.
   localparam int HOLD_OFF_CYCLES = 300;
   // Quiet cycles after the last reply, well beyond the latency of one transaction.
   localparam int DRAIN_CYCLES    = 40;
   localparam int RANDOM_ITEMS    = 140;
   // Time limit in ns, well beyond what the slowest correct run needs.
   localparam int TIMEOUT_NS      = 400_000;

   typedef struct packed {
      kind_type             kind;
      logic [CLASS_W-1:0]   class_id;
      logic [RECORD_W-1:0]  record_id;
      logic [ARRIVAL_W-1:0] arrival_time;
      logic [SEQ_W-1:0]     sequence_number;
      logic                 is_waiting;
   } request_type;

   typedef struct packed {
      status_type          status;
      logic                found;
      logic [RECORD_W-1:0] removed_record;
      logic [COUNT_W-1:0]  class_count;
   } reply_type;

   typedef struct packed {
      logic [CLASS_W-1:0]   class_id;
      logic [ARRIVAL_W-1:0] arrival_time;
      logic [SEQ_W-1:0]     sequence_number;
      logic [RECORD_W-1:0]  record_id;
   } entry_type;

   logic clock = 1'b0;
   logic reset;

   pcq_req_if req_ch ();
   pcq_rsp_if rsp_ch ();

   // The waiting list as the block should hold it, kept in sorted order, and the
   // replies that the block still owes, oldest first.
   entry_type waiting_list[$];
   reply_type owed_replies[$];

   int error_count       = 0;
   int sender_idle_pct   = 0;
   int receiver_idle_pct = 0;

   // A test asks for a receiver hold-off by bumping the request count; the
   // receiver process notices the difference and counts the stall out itself.
   int hold_off_requests = 0;
   int hold_off_served   = 0;
   int hold_left         = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   per_class_ordered_wait_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .TIME_BITS   (TIME_BITS)
   ) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // True when a stored entry sorts strictly ahead of the given key. A new entry
   // goes before every entry that is not strictly ahead, so equal keys put the
   // newcomer first.
   function automatic logic sorts_ahead(entry_type stored, entry_type key);
      if (stored.class_id != key.class_id) return stored.class_id < key.class_id;
      if (stored.arrival_time != key.arrival_time)
         return stored.arrival_time < key.arrival_time;
      return stored.sequence_number < key.sequence_number;
   endfunction

   // Applies one accepted request to the waiting list and works out the reply.
   function automatic reply_type serve_request(request_type req);
      reply_type rep;
      entry_type entry;
      int        pos;
      int        tally;
      rep = '{status: STATUS_DONE, found: 1'b0, removed_record: '0, class_count: '0};
      case (req.kind)
         KIND_INSERT: begin
            // A request that is not waiting is skipped even when the list is full.
            if (!req.is_waiting) begin
               rep.status = STATUS_SKIPPED;
            end else if (waiting_list.size() >= QUEUE_DEPTH) begin
               rep.status = STATUS_FULL;
            end else begin
               entry = '{class_id: req.class_id,
                         arrival_time: req.arrival_time & TIME_MASK,
                         sequence_number: req.sequence_number,
                         record_id: req.record_id};
               pos = 0;
               while (pos < waiting_list.size() && sorts_ahead(waiting_list[pos], entry))
                  pos++;
               waiting_list.insert(pos, entry);
            end
         end
         KIND_REMOVE: begin
            pos = 0;
            while (pos < waiting_list.size() && waiting_list[pos].class_id != req.class_id)
               pos++;
            if (pos < waiting_list.size()) begin
               rep.found = 1'b1;
               rep.removed_record = waiting_list[pos].record_id;
               waiting_list.delete(pos);
            end else begin
               rep.status = STATUS_EMPTY;
            end
         end
         KIND_CLEAR: begin
            waiting_list.delete();
         end
         default: begin
            // The unused kind changes nothing and only reports the count.
         end
      endcase
      tally = 0;
      foreach (waiting_list[i])
         if (waiting_list[i].class_id == req.class_id) tally++;
      rep.class_count = COUNT_W'(tally);
      return rep;
   endfunction

   function automatic request_type make_item(kind_type kind, logic [CLASS_W-1:0] class_id,
                                             logic [ARRIVAL_W-1:0] arrival_time,
                                             logic [SEQ_W-1:0] sequence_number,
                                             logic [RECORD_W-1:0] record_id,
                                             logic is_waiting);
      request_type req;
      req.kind            = kind;
      req.class_id        = class_id;
      req.record_id       = record_id;
      req.arrival_time    = arrival_time;
      req.sequence_number = sequence_number;
      req.is_waiting      = is_waiting;
      return req;
   endfunction

   // Classes come mostly from a small pool so that entries share a class and
   // removes find something; the extremes and wide random values still appear.
   function automatic logic [CLASS_W-1:0] pick_class();
      case ($urandom_range(9))
         0:       return '0;
         1:       return '1;
         2:       return CLASS_W'($urandom());
         default: return CLASS_W'($urandom_range(1, 4));
      endcase
   endfunction

   // Small timestamps and sequence numbers give many ties; wide ones toggle every bit.
   function automatic logic [ARRIVAL_W-1:0] pick_time();
      case ($urandom_range(3))
         0:       return '0;
         1:       return '1;
         2:       return {8'($urandom()), 32'($urandom())};
         default: return ARRIVAL_W'($urandom_range(0, 5));
      endcase
   endfunction

   function automatic logic [SEQ_W-1:0] pick_sequence();
      if ($urandom_range(2) == 0) return SEQ_W'($urandom());
      return SEQ_W'($urandom_range(0, 3));
   endfunction

   // Mostly inserts and removes of classes that are present, so the list keeps
   // growing and shrinking; a few skipped inserts, clears and unused kinds.
   function automatic request_type random_request();
      request_type req;
      int          pick;
      pick = $urandom_range(99);
      req = make_item(KIND_INSERT, pick_class(), pick_time(), pick_sequence(),
                      RECORD_W'($urandom()), 1'b1);
      if (pick < 52) begin
         req.kind = KIND_INSERT;
      end else if (pick < 90) begin
         req.kind = KIND_REMOVE;
         req.is_waiting = 1'($urandom());
         if (waiting_list.size() != 0 && $urandom_range(4) != 0)
            req.class_id = waiting_list[$urandom_range(waiting_list.size() - 1)].class_id;
      end else if (pick < 97) begin
         req.is_waiting = 1'b0;
      end else if (pick < 99) begin
         req.kind = KIND_CLEAR;
      end else begin
         req.kind = kind_type'(KIND_UNUSED);
      end
      return req;
   endfunction

   // Offers one request transaction and predicts its reply once it is taken. When
   // the sender does not idle, valid simply stays high from the previous request.
   task automatic send_item(request_type req);
      if ($urandom_range(99) < sender_idle_pct) begin
         req_ch.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < sender_idle_pct);
      end
      req_ch.valid           <= 1'b1;
      req_ch.kind            <= req.kind;
      req_ch.class_id        <= req.class_id;
      req_ch.record_id       <= req.record_id;
      req_ch.arrival_time    <= req.arrival_time;
      req_ch.sequence_number <= req.sequence_number;
      req_ch.is_waiting      <= req.is_waiting;
      do @(posedge clock); while (!req_ch.ready);
      owed_replies.push_back(serve_request(req));
   endtask

   // The sender stops and waits until every owed reply has come back. At least
   // one edge passes, so valid is never lowered and raised in one time step.
   task automatic wait_for_replies();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (owed_replies.size() != 0);
   endtask

   task automatic report_mismatch(string field, logic [63:0] want, logic [63:0] got);
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      error_count++;
   endtask

   // Extremes of every field, the tie rule, an empty class, a skipped insert, the
   // unused kind and a clear, each shown through the removes that follow.
   task automatic test_directed_cases();
      send_item(make_item(KIND_REMOVE, '0, '0, '0, '0, 1'b1));
      send_item(make_item(KIND_INSERT, '0, '0, '0, '0, 1'b1));
      send_item(make_item(KIND_INSERT, '1, '1, '1, '1, 1'b1));
      // Same key as the first entry: this record must come out first.
      send_item(make_item(KIND_INSERT, '0, '0, '0, 31'd1, 1'b1));
      send_item(make_item(KIND_INSERT, '0, '0, 16'd1, 31'd2, 1'b1));
      send_item(make_item(KIND_INSERT, '0, '0, '0, 31'd3, 1'b0));
      send_item(make_item(kind_type'(KIND_UNUSED), '0, '1, '1, '1, 1'b1));
      repeat (4) send_item(make_item(KIND_REMOVE, '0, '1, '1, '1, 1'b0));
      send_item(make_item(KIND_REMOVE, '1, '0, '0, '0, 1'b1));
      // Later arrivals inserted first must still leave in arrival order.
      send_item(make_item(KIND_INSERT, 16'd5, 40'd30, '0, 31'd10, 1'b1));
      send_item(make_item(KIND_INSERT, 16'd5, 40'd20, '0, 31'd11, 1'b1));
      send_item(make_item(KIND_INSERT, 16'd5, 40'd10, '0, 31'd12, 1'b1));
      send_item(make_item(KIND_INSERT, 16'd4, 40'd20, '0, 31'd13, 1'b1));
      send_item(make_item(KIND_REMOVE, 16'd5, '0, '0, '0, 1'b1));
      send_item(make_item(KIND_CLEAR, 16'd5, '0, '0, '0, 1'b1));
      send_item(make_item(KIND_REMOVE, 16'd5, '0, '0, '0, 1'b1));
      send_item(make_item(KIND_REMOVE, 16'd4, '0, '0, '0, 1'b1));
      wait_for_replies();
   endtask

   // Fills the whole store with random entries, pushes past the limit, then drains
   // it again through removes of present classes mixed with misses.
   task automatic test_full_store();
      request_type req;
      send_item(make_item(KIND_CLEAR, '0, '0, '0, '0, 1'b1));
      while (waiting_list.size() < QUEUE_DEPTH) begin
         req = random_request();
         req.kind = KIND_INSERT;
         req.is_waiting = 1'b1;
         send_item(req);
      end
      repeat (3) begin
         req = random_request();
         req.kind = KIND_INSERT;
         req.is_waiting = 1'b1;
         send_item(req);
      end
      req.is_waiting = 1'b0;
      send_item(req);
      while (waiting_list.size() != 0) begin
         req = random_request();
         req.kind = KIND_REMOVE;
         if ($urandom_range(7) != 0)
            req.class_id = waiting_list[$urandom_range(waiting_list.size() - 1)].class_id;
         send_item(req);
      end
      wait_for_replies();
   endtask

   task automatic test_random_traffic(int sender_pct, int receiver_pct, int count);
      sender_idle_pct   = sender_pct;
      receiver_idle_pct = receiver_pct;
      repeat (count) send_item(random_request());
      wait_for_replies();
   endtask

   // The receiver holds off for a long stretch while the sender keeps offering
   // requests back to back, so the block fills up and stops taking transactions.
   task automatic test_receiver_hold_off();
      int saved_pct;
      saved_pct = sender_idle_pct;
      sender_idle_pct = 0;
      hold_off_requests++;
      repeat (12) send_item(random_request());
      sender_idle_pct = saved_pct;
      wait_for_replies();
   endtask

   // Receiver: random stalls, or a counted hold-off when a test asks for one.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_off_served != hold_off_requests) begin
         hold_off_served <= hold_off_requests;
         hold_left       <= HOLD_OFF_CYCLES;
         rsp_ch.ready    <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left    <= hold_left - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= receiver_idle_pct);
      end
   end

   // Every reply transaction is matched against the oldest owed reply, field by field.
   always @(posedge clock) begin : check_reply
      reply_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (owed_replies.size() == 0) begin
            $display("%0t ns: reply with none owed, status %0d record %0d count %0d",
                     $time, rsp_ch.status, rsp_ch.removed_record, rsp_ch.class_count);
            error_count++;
         end else begin
            want = owed_replies.pop_front();
            if (rsp_ch.status !== want.status)
               report_mismatch("status", 64'(want.status), 64'(rsp_ch.status));
            if (rsp_ch.found !== want.found)
               report_mismatch("found", 64'(want.found), 64'(rsp_ch.found));
            if (rsp_ch.removed_record !== want.removed_record)
               report_mismatch("removed_record", 64'(want.removed_record),
                               64'(rsp_ch.removed_record));
            if (rsp_ch.class_count !== want.class_count)
               report_mismatch("class_count", 64'(want.class_count),
                               64'(rsp_ch.class_count));
         end
      end
   end

   initial begin
      #(TIMEOUT_NS);
      $display("per_class_ordered_wait_queue_tb NOT OK");
      $finish;
   end

   initial begin
      reset                  = 1'b1;
      req_ch.valid           = 1'b0;
      req_ch.kind            = KIND_INSERT;
      req_ch.class_id        = '0;
      req_ch.record_id       = '0;
      req_ch.arrival_time    = '0;
      req_ch.sequence_number = '0;
      req_ch.is_waiting      = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // First phase: the sender idles a little and the receiver a lot.
      sender_idle_pct   = 32;
      receiver_idle_pct = 71;
      test_directed_cases();
      test_full_store();
      test_random_traffic(32, 71, RANDOM_ITEMS);
      // Second phase: the other way round, with the long hold-off in it.
      test_random_traffic(71, 32, RANDOM_ITEMS);
      test_receiver_hold_off();
      // Last phase: neither side idles.
      test_random_traffic(0, 0, RANDOM_ITEMS);

      wait_for_replies();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("per_class_ordered_wait_queue_tb OK");
      end else begin
         $display("per_class_ordered_wait_queue_tb NOT OK");
      end
      $finish;
   end

endmodule

// ----- files.f -----
hw/rtl/pcq_pkg.sv
hw/rtl/pcq_req_if.sv
hw/rtl/pcq_rsp_if.sv
hw/rtl/pcq_cell.sv
hw/rtl/per_class_ordered_wait_queue.sv
dv/per_class_ordered_wait_queue_tb.sv
